/* hw/rtl/sta_pkg.sv */
// ----------------------------------------------------------------------------
// sta_pkg
// Types and codes shared by the seat table allocator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sta_pkg;

  localparam int SEAT_W        = 4;
  localparam int SEAT_CODES    = 1 << SEAT_W;
  localparam int POS_W         = 4;
  localparam int COUNT_W       = 5;
  localparam int ADDR_FIELD_W  = 32;
  localparam int PORT_FIELD_W  = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_READ   = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_PRESENT    = 3'd1,
    ST_NO_SEAT    = 3'd2,
    ST_READ_OK    = 3'd3,
    ST_READ_RANGE = 3'd4,
    ST_DELETED    = 3'd5,
    ST_DEL_MISS   = 3'd6,
    ST_UNUSED     = 3'd7
  } status_t;

  // input word
  typedef struct packed {
    op_t                     op;
    logic [ADDR_FIELD_W-1:0] wan_address;
    logic [PORT_FIELD_W-1:0] wan_port_number;
    logic [ADDR_FIELD_W-1:0] lan_address;
    logic [PORT_FIELD_W-1:0] lan_port_number;
    logic [SEAT_W-1:0]       requested_seat;
    logic [POS_W-1:0]        list_position;
  } sta_in_t;

  // result word
  typedef struct packed {
    status_t                 status;
    logic [SEAT_W-1:0]       seat;
    logic [ADDR_FIELD_W-1:0] out_wan_address;
    logic [PORT_FIELD_W-1:0] out_wan_port;
    logic [ADDR_FIELD_W-1:0] out_lan_address;
    logic [PORT_FIELD_W-1:0] out_lan_port;
    logic [COUNT_W-1:0]      entry_count;
  } sta_out_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] wan_address;
    logic [PORT_FIELD_W-1:0] wan_port;
    logic [ADDR_FIELD_W-1:0] lan_address;
    logic [PORT_FIELD_W-1:0] lan_port;
    logic [SEAT_W-1:0]       seat;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/seat_table_allocator_unit.sv */
// ----------------------------------------------------------------------------
// seat_table_allocator_unit
// Ordered client table with seat allocation, held in one entry memory.
// ----------------------------------------------------------------------------
//
//  channel   signals                         word
//  --------  ------------------------------  ---------
//  input     in_valid / in_ready / in_data   sta_in_t
//  output    out_valid / out_ready / out_data sta_out_t
//
//  add: one memory read per stored entry, then grant, then result
//  read: one memory read, then result; delete: write back one place lower
//  per later entry, then result; out of range: straight to the result
//  other words: straight to the result
//  one word in flight; the next is taken while the previous result waits
//  a stalled output holds the finished result until the slot frees
//  reset empties the table at once; entry memory contents are not cleared
//
`default_nettype none

module seat_table_allocator_unit
  import sta_pkg::*;
#(
  parameter int SEATS = 10
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sta_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sta_out_t      out_data
);

  localparam int AW = (SEATS > 1) ? $clog2(SEATS) : 1;
  localparam int CW = $clog2(SEATS + 1);
  localparam int REST_W = $bits(sta_out_t) - $bits(status_t);
  localparam logic [SEAT_W:0]  SEATS_S = (SEAT_W + 1)'(SEATS);
  localparam logic [COUNT_W-1:0] SEATS_C = COUNT_W'(SEATS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_GRANT = 6'b000100,
    S_RDATA = 6'b001000,
    S_SHIFT = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t                state;
  sta_in_t               cmd;
  sta_out_t              res;
  logic [CW-1:0]         used;
  logic [CW-1:0]         idx;
  logic [SEAT_CODES-1:0] taken;

  // entry memory
  entry_t                mem [SEATS];
  entry_t                rd_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  entry_t                wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // derived values
  logic [COUNT_W-1:0] used_c;
  logic [COUNT_W-1:0] in_pos_c;
  logic [CW:0]        idx_p1;
  logic [CW:0]        idx_p2;
  logic [CW:0]        used_w;
  logic               key_hit;
  logic [SEAT_W-1:0]  grant;
  logic               grant_ok;
  status_t            start_status;
  state_t             start_state;

  assign used_c   = COUNT_W'(used);
  assign in_pos_c = COUNT_W'(in_data.list_position);
  assign idx_p1   = (CW + 1)'(idx) + (CW + 1)'(1);
  assign idx_p2   = (CW + 1)'(idx) + (CW + 1)'(2);
  assign used_w   = (CW + 1)'(used);
  assign key_hit  = (rd_data.wan_address == cmd.wan_address) &&
                    (rd_data.wan_port == cmd.wan_port_number) &&
                    (rd_data.lan_address == cmd.lan_address) &&
                    (rd_data.lan_port == cmd.lan_port_number);

  // first status and state for an incoming word
  always_comb begin
    start_status = ST_ADDED;
    start_state  = S_RESP;
    unique case (in_data.op)
      OP_ADD: begin
        start_state = (used == '0) ? S_GRANT : S_SCAN;
      end
      OP_READ: begin
        if (in_pos_c < used_c) begin
          start_state = S_RDATA;
        end else begin
          start_status = ST_READ_RANGE;
        end
      end
      OP_DELETE: begin
        if (in_pos_c < used_c) begin
          start_status = ST_DELETED;
          if (in_pos_c + COUNT_W'(1) != used_c) begin
            start_state = S_SHIFT;
          end
        end else begin
          start_status = ST_DEL_MISS;
        end
      end
      OP_NONE: begin
        start_status = ST_READ_RANGE;
      end
      default: begin
        start_status = ST_READ_RANGE;
      end
    endcase
  end

  // seat grant: requested seat if inside the table and free, else lowest free seat above zero
  always_comb begin
    grant    = '0;
    grant_ok = 1'b0;
    if (({1'b0, cmd.requested_seat} < SEATS_S) && !taken[cmd.requested_seat]) begin
      grant    = cmd.requested_seat;
      grant_ok = 1'b1;
    end else begin
      for (int s = SEATS - 1; s >= 1; s--) begin
        if (!taken[s]) begin
          grant    = SEAT_W'(s);
          grant_ok = 1'b1;
        end
      end
    end
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd_en = 1'b1;
          if (in_data.op == OP_DELETE) begin
            rd_addr = AW'(in_data.list_position + POS_W'(1));
          end else if (in_data.op == OP_READ) begin
            rd_addr = in_data.list_position[AW-1:0];
          end
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[AW-1:0];
      end
      S_GRANT: begin
        wr_en           = grant_ok && (used_c < SEATS_C);
        wr_addr         = used[AW-1:0];
        wr_data.wan_address = cmd.wan_address;
        wr_data.wan_port    = cmd.wan_port_number;
        wr_data.lan_address = cmd.lan_address;
        wr_data.lan_port    = cmd.lan_port_number;
        wr_data.seat        = grant;
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        rd_en   = 1'b1;
        rd_addr = idx_p2[AW-1:0];
      end
      S_RDATA, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_data;
            res   <= sta_out_t'({start_status, REST_W'(0)});
            taken <= '0;
            idx   <= (in_data.op == OP_DELETE) ? CW'(in_data.list_position) : '0;
            state <= start_state;
            // last entry removed needs no shifting
            if ((in_data.op == OP_DELETE) && (start_status == ST_DELETED) &&
                (start_state == S_RESP)) begin
              used <= used - CW'(1);
            end
          end
        end
        // compare one stored entry per cycle, collect seats in use
        S_SCAN: begin
          if (key_hit) begin
            res.status <= ST_PRESENT;
            res.seat   <= rd_data.seat;
            state      <= S_RESP;
          end else begin
            taken[rd_data.seat] <= 1'b1;
            idx <= idx_p1[CW-1:0];
            if (idx_p1 == used_w) begin
              state <= S_GRANT;
            end
          end
        end
        S_GRANT: begin
          if (grant_ok && (used_c < SEATS_C)) begin
            res.status <= ST_ADDED;
            res.seat   <= grant;
            used       <= used + CW'(1);
          end else begin
            res.status <= ST_NO_SEAT;
          end
          state <= S_RESP;
        end
        S_RDATA: begin
          res.status          <= ST_READ_OK;
          res.seat            <= rd_data.seat;
          res.out_wan_address <= rd_data.wan_address;
          res.out_wan_port    <= rd_data.wan_port;
          res.out_lan_address <= rd_data.lan_address;
          res.out_lan_port    <= rd_data.lan_port;
          state               <= S_RESP;
        end
        // move entry idx+1 down to idx
        S_SHIFT: begin
          idx <= idx_p1[CW-1:0];
          if (idx_p2 == used_w) begin
            used  <= used - CW'(1);
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_data             <= res;
            out_data.entry_count <= used_c;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sta_checker.sv */
// ----------------------------------------------------------------------------
// sta_checker
// Port-level checks for the seat table allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_checker
  import sta_pkg::*;
#(
  parameter int SEATS = 10
) (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire sta_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire sta_out_t out_data
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word at a time: input closes after an accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // table never exceeds its capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count <= COUNT_W'(SEATS))
    else $error("entry count above capacity");

  // a granted seat lies inside the table
  a_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_ADDED) |->
      {1'b0, out_data.seat} < (SEAT_W + 1)'(SEATS))
    else $error("granted seat out of range");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind seat_table_allocator_unit sta_checker #(.SEATS(SEATS)) u_sta_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* test/seat_table_allocator_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seat_table_allocator_unit_test
// Drives add, read, delete and unused words into the seat table allocator and checks
// every result word against a table model kept in step with the accepted
// words. Sender bursts and receiver stalls are random throughout.
// ----------------------------------------------------------------------------

module seat_table_allocator_unit_test;
  import sta_pkg::*;

  localparam int SEATS = 10;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  sta_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sta_out_t out_data;

  // table model state
  entry_t   seat_entry [SEATS];
  int       seats_filled = 0;

  sta_out_t seat_replies [$];
  int       faults = 0;
  int       words_sent = 0;
  int       burst_left = 0;
  int       status_seen [8];

  // client key pool for repeated and near-miss adds
  logic [31:0] pool_wa [16];
  logic [15:0] pool_wp [16];
  logic [31:0] pool_la [16];
  logic [15:0] pool_lp [16];

  seat_table_allocator_unit #(
    .SEATS(SEATS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // table model: one word in, one result out
  function automatic sta_out_t apply_table_op(sta_in_t w);
    sta_out_t r;
    logic [15:0] busy;
    bit hit;
    int grant;
    int pos;
    int i;
    r = '0;
    busy = '0;
    hit = 1'b0;
    grant = SEATS;
    pos = int'(w.list_position);
    case (w.op)
      OP_ADD: begin
        for (i = 0; i < seats_filled; i++) begin
          if (!hit && seat_entry[i].wan_address == w.wan_address &&
              seat_entry[i].wan_port == w.wan_port_number &&
              seat_entry[i].lan_address == w.lan_address &&
              seat_entry[i].lan_port == w.lan_port_number) begin
            hit = 1'b1;
            r.status = ST_PRESENT;
            r.seat = seat_entry[i].seat;
          end
          busy[seat_entry[i].seat] = 1'b1;
        end
        if (!hit) begin
          // requested seat first if inside the table and free, else lowest free seat above zero
          if (int'(w.requested_seat) < SEATS && !busy[w.requested_seat])
            grant = int'(w.requested_seat);
          else
            for (i = 1; i < SEATS; i++)
              if (grant == SEATS && !busy[i]) grant = i;
          if (grant >= SEATS || seats_filled >= SEATS) begin
            r.status = ST_NO_SEAT;
          end else begin
            seat_entry[seats_filled].wan_address = w.wan_address;
            seat_entry[seats_filled].wan_port    = w.wan_port_number;
            seat_entry[seats_filled].lan_address = w.lan_address;
            seat_entry[seats_filled].lan_port    = w.lan_port_number;
            seat_entry[seats_filled].seat        = 4'(grant);
            seats_filled++;
            r.status = ST_ADDED;
            r.seat = 4'(grant);
          end
        end
      end
      OP_READ: begin
        if (pos >= seats_filled) begin
          r.status = ST_READ_RANGE;
        end else begin
          r.status          = ST_READ_OK;
          r.seat            = seat_entry[pos].seat;
          r.out_wan_address = seat_entry[pos].wan_address;
          r.out_wan_port    = seat_entry[pos].wan_port;
          r.out_lan_address = seat_entry[pos].lan_address;
          r.out_lan_port    = seat_entry[pos].lan_port;
        end
      end
      OP_DELETE: begin
        if (pos >= seats_filled) begin
          r.status = ST_DEL_MISS;
        end else begin
          // close the gap, keeping order
          for (i = pos; i + 1 < seats_filled; i++)
            seat_entry[i] = seat_entry[i + 1];
          seats_filled--;
          r.status = ST_DELETED;
        end
      end
      default: begin
        r.status = ST_READ_RANGE;
      end
    endcase
    r.entry_count = 5'(seats_filled);
    return r;
  endfunction

  function automatic sta_in_t client_word(op_t op, logic [31:0] wa, logic [15:0] wp,
                                          logic [31:0] la, logic [15:0] lp,
                                          logic [3:0] req, logic [3:0] pos);
    sta_in_t w;
    w.op = op;
    w.wan_address = wa;
    w.wan_port_number = wp;
    w.lan_address = la;
    w.lan_port_number = lp;
    w.requested_seat = req;
    w.list_position = pos;
    return w;
  endfunction

  // send one word; valid stays up within a burst, drops for a random gap after
  task automatic send_word(input sta_in_t w);
    int gap;
    sta_out_t want_word;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    // ready only moves at the rising edge, so check it at the falling edge before
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    want_word = apply_table_op(w);
    seat_replies = {seat_replies, want_word};
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // receiver stall pattern, with the mode picked at random anew for each stretch
  initial begin : ready_pattern
    int mode;
    int stall_left;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat (48) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: begin
            if (stall_left > 0) begin
              out_ready <= 1'b0;
              stall_left--;
            end else begin
              out_ready <= 1'b1;
              stall_left = $urandom_range(0, 30);
            end
          end
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      faults++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    sta_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (seat_replies.size() == 0) begin
        $error("result word with nothing pending: status %0d", out_data.status);
        faults++;
      end else begin
        want = seat_replies.pop_front();
        status_seen[want.status]++;
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("seat", 32'(want.seat), 32'(out_data.seat));
        check_field("out_wan_address", want.out_wan_address, out_data.out_wan_address);
        check_field("out_wan_port", 32'(want.out_wan_port), 32'(out_data.out_wan_port));
        check_field("out_lan_address", want.out_lan_address, out_data.out_lan_address);
        check_field("out_lan_port", 32'(want.out_lan_port), 32'(out_data.out_lan_port));
        check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
      end
    end
  end

  // seat grant rules on an empty table
  task automatic test_add_rules();
    // seat zero requested and free
    send_word(client_word(OP_ADD, 32'h0, 16'h0, 32'h0, 16'h0, 4'd0, 4'd0));
    // same key again reports its seat
    send_word(client_word(OP_ADD, 32'h0, 16'h0, 32'h0, 16'h0, 4'd5, 4'd15));
    // any seat request gets lowest free above zero
    send_word(client_word(OP_ADD, '1, '1, '1, '1, 4'd15, 4'd15));
    // seat zero taken, falls back
    send_word(client_word(OP_ADD, 32'hc0a8_0001, 16'd80, 32'h0a00_0001, 16'd8080,
                          4'd0, 4'd0));
    send_word(client_word(OP_ADD, 32'h0102_0304, 16'd1, 32'h0506_0708, 16'd2,
                          4'(SEATS - 1), 4'd0));
    // request of exactly SEATS means any seat
    send_word(client_word(OP_ADD, 32'h8000_0000, 16'h8000, 32'h0000_0001, 16'h0001,
                          4'(SEATS), 4'd0));
  endtask

  task automatic test_read_delete();
    send_word(client_word(OP_READ, '0, '0, '0, '0, 4'd0, 4'd0));
    send_word(client_word(OP_READ, '1, '1, '1, '1, 4'd15, 4'd4));
    // one past the end
    send_word(client_word(OP_READ, '0, '0, '0, '0, 4'd0, 4'd5));
    send_word(client_word(OP_DELETE, '0, '0, '0, '0, 4'd0, 4'd15));
    // middle entry, later ones move down
    send_word(client_word(OP_DELETE, '0, '0, '0, '0, 4'd0, 4'd1));
  endtask

  // fill every seat, then the adds with no seat left
  task automatic test_full_table();
    send_word(client_word(OP_DELETE, '0, '0, '0, '0, 4'd0, 4'd0));
    repeat (SEATS - 3)
      send_word(client_word(OP_ADD, $urandom, 16'($urandom), $urandom, 16'($urandom),
                            4'd15, 4'd0));
    send_word(client_word(OP_ADD, 32'h5555_5555, 16'h5555, 32'haaaa_aaaa, 16'haaaa,
                          4'd0, 4'd0));
    send_word(client_word(OP_ADD, 32'haaaa_aaaa, 16'haaaa, 32'h5555_5555, 16'h5555,
                          4'd0, 4'd0));
    send_word(client_word(OP_READ, '0, '0, '0, '0, 4'd0, 4'(SEATS - 1)));
    send_word(client_word(OP_DELETE, '0, '0, '0, '0, 4'd0, 4'(SEATS - 1)));
    send_word(client_word(OP_DELETE, '0, '0, '0, '0, 4'd0, 4'd0));
  endtask

  task automatic test_unused_op();
    send_word(client_word(OP_NONE, '1, '1, '1, '1, 4'd15, 4'd0));
  endtask

  task automatic test_random_traffic(input int count);
    sta_in_t w;
    int roll;
    int k;
    int i;
    for (i = 0; i < 16; i++) begin
      pool_wa[i] = $urandom;
      pool_wp[i] = 16'($urandom);
      pool_la[i] = $urandom;
      pool_lp[i] = 16'($urandom);
    end
    repeat (count) begin
      w = sta_in_t'({$urandom, $urandom, $urandom, $urandom});
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        w.op = OP_ADD;
        k = $urandom_range(0, 15);
        if ($urandom_range(0, 49) == 0) begin
          pool_wa[k] = $urandom;
          pool_lp[k] = 16'($urandom);
        end
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          w.wan_address = pool_wa[k];
          w.wan_port_number = pool_wp[k];
          w.lan_address = pool_la[k];
          w.lan_port_number = pool_lp[k];
          // near miss: one key field differs
          if (roll >= 60)
            case ($urandom_range(0, 3))
              0: w.wan_address = pool_wa[k] ^ (32'd1 << $urandom_range(0, 31));
              1: w.wan_port_number = pool_wp[k] ^ (16'd1 << $urandom_range(0, 15));
              2: w.lan_address = pool_la[k] ^ (32'd1 << $urandom_range(0, 31));
              default: w.lan_port_number = pool_lp[k] ^ (16'd1 << $urandom_range(0, 15));
            endcase
        end
        if ($urandom_range(0, 9) < 7) w.requested_seat = 4'($urandom_range(0, SEATS - 1));
      end else begin
        if (roll < 70) w.op = OP_READ;
        else if (roll < 95) w.op = OP_DELETE;
        else w.op = OP_NONE;
        if ($urandom_range(0, 3) != 0) w.list_position = 4'($urandom_range(0, seats_filled));
      end
      send_word(w);
    end
  endtask

  // run limit
  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_add_rules();
    test_read_delete();
    test_full_table();
    test_unused_op();
    test_random_traffic(1950);

    park_input();
    while (seat_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d words: %0d added, %0d present, %0d no seat, %0d read, %0d read miss,",
             words_sent, status_seen[ST_ADDED], status_seen[ST_PRESENT],
             status_seen[ST_NO_SEAT], status_seen[ST_READ_OK], status_seen[ST_READ_RANGE]);
    $display("%0d deleted, %0d delete miss, with random bursts and output stalls",
             status_seen[ST_DELETED], status_seen[ST_DEL_MISS]);
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sta_pkg.sv
hw/rtl/seat_table_allocator_unit.sv
hw/rtl/sta_checker.sv
test/seat_table_allocator_unit_test.sv
